// ----- sv/hmlp_pkg.sv -----
// ----------------------------------------------------------------------------
// hmlp_pkg
// Shared types and constants for the linear-probe hash map.
// ----------------------------------------------------------------------------
package hmlp_pkg;

   localparam int unsigned SLOTS_DEFAULT = 1024;
   localparam int unsigned CFG_W         = 11;

   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 11'd512;

   localparam logic [63:0] EMPTY_KEY = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] MIX_A     = 64'd14029467366897019727;
   localparam logic [63:0] MIX_B     = 64'd1609587929392839161;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_RESERVED = 2'd2;

   localparam logic MODE_SET = 1'b0;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_MOD,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_CHECK
   } back_state_type;

   // classified request, as handed from front to back
   typedef struct packed {
      logic        mode;
      logic        reserved;
      logic [63:0] key;
      logic [63:0] value;
   } item_type;

endpackage

// ----- sv/hmlp_ram.sv -----
// ----------------------------------------------------------------------------
// hmlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmlp_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/hmlp_fifo.sv -----
// ----------------------------------------------------------------------------
// hmlp_fifo
// Two-entry queue between the hashing front end and the probing back end.
// ----------------------------------------------------------------------------
module hmlp_fifo #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ (push & ~full);
      rd_ptr_in = rd_ptr_ff ^ (pop & ~empty);
      count_in  = count_ff + 2'((push & ~full)) - 2'((pop & ~empty));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/hmlp_front.sv -----
// ----------------------------------------------------------------------------
// hmlp_front
// Accepts requests, flags the reserved key and hashes the key to a home slot
// on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module hmlp_front #(
   parameter int unsigned SLOTS = hmlp_pkg::SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic                     in_mode,
   input  logic [63:0]              in_key,
   input  logic [63:0]              in_value,
   output logic                     q_push,
   output hmlp_pkg::item_type       q_item,
   output logic [$clog2(SLOTS)-1:0] q_home,
   input  logic                     q_full
);

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam bit          POW2  = ((SLOTS & (SLOTS - 1)) == 0);
   // 2^32 mod SLOTS folds the high word; floor(2^32 / SLOTS) estimates the quotient
   localparam logic [31:0] RED_R   = 32'((64'd1 << 32) % 64'(SLOTS));
   localparam logic [31:0] RED_M   = 32'((64'd1 << 32) / 64'(SLOTS));
   localparam logic [31:0] SLOTS_W = 32'(SLOTS);

   hmlp_pkg::front_state_type st_ff, st_in;
   hmlp_pkg::item_type        item_ff, item_in;
   logic [63:0]       x_ff, x_in;
   logic [63:0]       acc_ff, acc_in;
   logic              phase_ff, phase_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [2:0]        step_ff, step_in;
   logic [IDX_W-1:0]  home_ff, home_in;
   logic [63:0]       mul_c;
   logic [31:0]       op_a, op_b;
   logic [63:0]       prod;
   logic [63:0]       sum;
   logic [63:0]       hash;
   logic [31:0]       red_fix;

   assign mul_c = phase_ff ? hmlp_pkg::MIX_B : hmlp_pkg::MIX_A;

   // multiplier operands: hash partial products, or the reduction steps
   always_comb begin
      op_a = (cnt_ff == 2'd1) ? x_ff[63:32] : x_ff[31:0];
      op_b = (cnt_ff == 2'd2) ? mul_c[63:32] : mul_c[31:0];
      if (st_ff == hmlp_pkg::F_MOD) begin
         if (step_ff < 3'd4) begin
            op_a = x_ff[63:32];
            op_b = RED_R;
         end else if (step_ff == 3'd4) begin
            op_a = x_ff[31:0];
            op_b = RED_M;
         end else begin
            op_a = acc_ff[31:0];
            op_b = SLOTS_W;
         end
      end
   end

   assign prod    = {32'd0, op_a} * {32'd0, op_b};
   assign sum     = (cnt_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};
   assign hash    = sum ^ (sum >> 32);
   assign red_fix = (x_ff[31:0] >= SLOTS_W) ? x_ff[31:0] - SLOTS_W : x_ff[31:0];

   assign in_ready = (st_ff == hmlp_pkg::F_IDLE) && enable;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         hmlp_pkg::F_IDLE: begin
            if (in_valid && enable) st_in = hmlp_pkg::F_MUL;
         end
         hmlp_pkg::F_MUL: begin
            if (cnt_ff == 2'd2 && phase_ff) begin
               st_in = POW2 ? hmlp_pkg::F_PUSH : hmlp_pkg::F_MOD;
            end
         end
         hmlp_pkg::F_MOD: begin
            if (step_ff == 3'd6) st_in = hmlp_pkg::F_PUSH;
         end
         hmlp_pkg::F_PUSH: begin
            if (!q_full) st_in = hmlp_pkg::F_IDLE;
         end
         default: st_in = hmlp_pkg::F_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in  = item_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      home_in  = home_ff;
      q_push   = 1'b0;
      case (st_ff)
         hmlp_pkg::F_IDLE: begin
            item_in.mode     = in_mode;
            item_in.key      = in_key;
            item_in.value    = in_value;
            item_in.reserved = (in_key == hmlp_pkg::EMPTY_KEY);
            x_in     = in_key ^ (in_key >> 33);
            phase_in = 1'b0;
            cnt_in   = 2'd0;
         end
         hmlp_pkg::F_MUL: begin
            acc_in = sum;
            cnt_in = (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               if (!phase_ff) begin
                  x_in     = sum ^ (sum >> 29);
                  phase_in = 1'b1;
               end else begin
                  x_in    = hash;
                  home_in = POW2 ? hash[IDX_W-1:0] : '0;
                  step_in = 3'd0;
               end
            end
         end
         hmlp_pkg::F_MOD: begin
            // four folds of the high word bring the hash under 2^32, then
            // quotient estimate, remainder, and one corrective subtract
            step_in = step_ff + 3'd1;
            if (step_ff < 3'd4) begin
               x_in = prod + {32'd0, x_ff[31:0]};
            end else if (step_ff == 3'd4) begin
               acc_in = {32'd0, prod[63:32]};
            end else if (step_ff == 3'd5) begin
               x_in = {32'd0, x_ff[31:0] - prod[31:0]};
            end else begin
               home_in = red_fix[IDX_W-1:0];
            end
         end
         hmlp_pkg::F_PUSH: begin
            q_push = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign q_item = item_ff;
   assign q_home = home_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= hmlp_pkg::F_IDLE;
         phase_ff <= 1'b0;
         cnt_ff   <= 2'd0;
         step_ff  <= 3'd0;
      end else begin
         st_ff    <= st_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      home_ff <= home_in;
   end

endmodule

// ----- sv/hmlp_back.sv -----
// ----------------------------------------------------------------------------
// hmlp_back
// Clears the key store after reset, then walks the probe chain for each
// queued request, updates the stores and holds the response.
// ----------------------------------------------------------------------------
module hmlp_back #(
   parameter int unsigned SLOTS = hmlp_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hmlp_pkg::CFG_W-1:0]  max_entries,
   output logic                        clearing,
   input  logic                        q_empty,
   input  hmlp_pkg::item_type          q_item,
   input  logic [$clog2(SLOTS)-1:0]    q_home,
   output logic                        q_pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [63:0]                 out_value,
   output logic                        out_inserted,
   output logic [1:0]                  out_status
);

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CNT_W = (IDX_W + 1 > hmlp_pkg::CFG_W) ? IDX_W + 1 : hmlp_pkg::CFG_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   hmlp_pkg::back_state_type st_ff, st_in;
   hmlp_pkg::item_type item_ff, item_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rv_ff, rv_in;
   logic [63:0]      rval_ff, rval_in;
   logic             rins_ff, rins_in;
   logic [1:0]       rst_ff, rst_in;

   logic [IDX_W-1:0] rd_addr, wr_addr, idx_next;
   logic             key_we, val_we;
   logic [63:0]      key_wdata, val_wdata;
   logic [63:0]      rd_key, rd_val;
   logic             hit, empty_slot, last, done, slot_free, room;

   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign hit        = (rd_key == item_ff.key);
   assign empty_slot = (rd_key == hmlp_pkg::EMPTY_KEY);
   assign last       = (n_ff == LAST_IDX);
   assign done       = item_ff.reserved | hit | empty_slot | last;
   assign slot_free  = ~rv_ff | out_ready;
   assign room       = (count_ff < CNT_W'(max_entries));

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         hmlp_pkg::B_CLEAR: if (clr_ff == LAST_IDX) st_in = hmlp_pkg::B_IDLE;
         hmlp_pkg::B_IDLE:  if (!q_empty) st_in = hmlp_pkg::B_CHECK;
         hmlp_pkg::B_CHECK: if (done && slot_free) st_in = hmlp_pkg::B_IDLE;
         default:           st_in = hmlp_pkg::B_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      item_in   = item_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      rv_in     = rv_ff & ~out_ready;
      rval_in   = rval_ff;
      rins_in   = rins_ff;
      rst_in    = rst_ff;
      rd_addr   = idx_ff;
      wr_addr   = idx_ff;
      key_we    = 1'b0;
      val_we    = 1'b0;
      key_wdata = item_ff.key;
      val_wdata = item_ff.value;
      q_pop     = 1'b0;
      case (st_ff)
         hmlp_pkg::B_CLEAR: begin
            key_we    = 1'b1;
            wr_addr   = clr_ff;
            key_wdata = hmlp_pkg::EMPTY_KEY;
            clr_in    = clr_ff + 1'b1;
         end
         hmlp_pkg::B_IDLE: begin
            q_pop   = ~q_empty;
            item_in = q_item;
            idx_in  = q_home;
            n_in    = '0;
            rd_addr = q_home;
         end
         hmlp_pkg::B_CHECK: begin
            if (done && slot_free) begin
               rv_in   = 1'b1;
               rins_in = 1'b0;
               rval_in = '0;
               if (item_ff.reserved) begin
                  rst_in = hmlp_pkg::STATUS_RESERVED;
               end else if (hit) begin
                  rst_in = hmlp_pkg::STATUS_OK;
                  if (item_ff.mode == hmlp_pkg::MODE_SET) begin
                     val_we  = 1'b1;
                     rval_in = item_ff.value;
                  end else begin
                     rval_in = rd_val;
                  end
               end else if (empty_slot && room) begin
                  key_we   = 1'b1;
                  val_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  rval_in  = item_ff.value;
                  rins_in  = 1'b1;
                  rst_in   = hmlp_pkg::STATUS_OK;
               end else begin
                  rst_in = hmlp_pkg::STATUS_FULL;
               end
            end else if (!done) begin
               idx_in  = idx_next;
               n_in    = n_ff + 1'b1;
               rd_addr = idx_next;
            end
         end
         default: begin
         end
      endcase
   end

   hmlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (key_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_key)
   );

   hmlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_addr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_val)
   );

   assign clearing     = (st_ff == hmlp_pkg::B_CLEAR);
   assign out_valid    = rv_ff;
   assign out_value    = rval_ff;
   assign out_inserted = rins_ff;
   assign out_status   = rst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= hmlp_pkg::B_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         st_ff    <= st_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff  <= idx_in;
      n_ff    <= n_in;
      rval_ff <= rval_in;
      rins_ff <= rins_in;
      rst_ff  <= rst_in;
   end

endmodule

// ----- sv/hash_map_linear_probe.sv -----
// ----------------------------------------------------------------------------
// hash_map_linear_probe
// 64-bit key to 64-bit value map, open addressing with linear probing.
// ----------------------------------------------------------------------------
// Each accepted request is hashed in the front end, popped from the queue by the back
// end and probed slot by slot; a modular reduction follows the hash if SLOTS is not a
// power of two. Throughput is set by the hash front end, or by the probe walk when
// that walk is longer.
// Reset: synchronous; a clearing pass marks every key slot empty, and req_tready
// stays low until it ends.
// ----------------------------------------------------------------------------
module hash_map_linear_probe #(
   parameter int unsigned SLOTS = hmlp_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [127:0]               req_tdata,  // key[63:0], value[127:64]
   input  logic                       req_tuser,  // mode
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,  // result_value[63:0]
   output logic [2:0]                 rsp_tuser,  // inserted[0], status[2:1]
   // max_entries register
   input  logic                       csr_we,
   input  logic [hmlp_pkg::CFG_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned Q_W   = $bits(hmlp_pkg::item_type) + IDX_W;

   logic [hmlp_pkg::CFG_W-1:0] max_entries_ff;
   logic                       clearing;
   logic                       q_push, q_full, q_pop, q_empty;
   hmlp_pkg::item_type         f_item, b_item;
   logic [IDX_W-1:0]           f_home, b_home;
   logic [Q_W-1:0]             q_head;
   logic                       rsp_inserted;
   logic [1:0]                 rsp_status;

   // configuration register; the user must write it only while the block is idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= hmlp_pkg::MAX_ENTRIES_RESET;
      end else if (csr_we) begin
         max_entries_ff <= csr_wdata;
      end
   end

   // front end: accept, flag reserved key, hash to home slot
   hmlp_front #(.SLOTS(SLOTS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (~clearing),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_mode  (req_tuser),
      .in_key   (req_tdata[63:0]),
      .in_value (req_tdata[127:64]),
      .q_push   (q_push),
      .q_item   (f_item),
      .q_home   (f_home),
      .q_full   (q_full)
   );

   // short queue so hashing of the next transaction overlaps the probe walk
   hmlp_fifo #(.WIDTH(Q_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_item, f_home}),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty)
   );

   assign b_item = q_head[Q_W-1:IDX_W];
   assign b_home = q_head[IDX_W-1:0];

   // back end: probe walk, store updates, response register
   hmlp_back #(.SLOTS(SLOTS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .max_entries  (max_entries_ff),
      .clearing     (clearing),
      .q_empty      (q_empty),
      .q_item       (b_item),
      .q_home       (b_home),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_value    (rsp_tdata),
      .out_inserted (rsp_inserted),
      .out_status   (rsp_status)
   );

   assign rsp_tuser = {rsp_status, rsp_inserted};

endmodule

// ----- sv/hmlp_checker.sv -----
// ----------------------------------------------------------------------------
// hmlp_checker
// Port-level checks for the hash map, bound to the top level.
// ----------------------------------------------------------------------------
module hmlp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [127:0]               req_tdata,
   input logic                       req_tuser,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [63:0]                rsp_tdata,
   input logic [2:0]                 rsp_tuser,
   input logic                       csr_we,
   input logic [hmlp_pkg::CFG_W-1:0] csr_wdata
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // an insertion always reports ok
   a_ins_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == hmlp_pkg::STATUS_OK)
      else $error("inserted with error status");

   // refused or reserved transactions carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] != hmlp_pkg::STATUS_OK |-> rsp_tdata == 64'd0)
      else $error("error response with nonzero value");

   // clearing pass keeps requests out right after reset
   a_clear: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block ready during clearing pass");

endmodule

bind hash_map_linear_probe hmlp_checker u_hmlp_checker (.*);
